### sv/stlg_pkg.sv
// ---------------------------------------------------------------------------
// stlg_pkg: shared types and codes of the sparse tree layer grouper
// Result word layout, item kinds, register indexes and queue sizing.
// ---------------------------------------------------------------------------
package stlg_pkg;

   localparam int KeyWidth   = 64;
   localparam int MaskWidth  = 64;
   localparam int IndexWidth = 30;
   localparam int ScaleWidth = 5;
   localparam int CsrIdxWidth = 2;

   // result queue: four words, room for the three words one child can cause
   localparam int QueueDepth    = 4;
   localparam int QueuePtrWidth = 2;
   localparam int QueueCntWidth = 3;

   localparam logic KIND_CHILD  = 1'b0;
   localparam logic KIND_PARENT = 1'b1;

   localparam logic [CsrIdxWidth-1:0] CSR_LAYER_SCALE = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_POOL_BASE   = 2'd1;

   localparam logic [ScaleWidth-1:0] LAYER_SCALE_RESET = 5'd8;

   typedef struct packed {
      logic                  item_kind;
      logic [IndexWidth-1:0] pool_index;
      logic [KeyWidth-1:0]   node_key;
      logic                  node_is_leaf;
      logic                  node_is_absolute;
      logic [IndexWidth-1:0] node_pointer;
      logic [MaskWidth-1:0]  node_mask;
      logic                  end_of_run;
      logic                  end_of_layer;
   } rsp_word_type;

endpackage

### sv/sparse_tree_layer_grouper.sv
// ---------------------------------------------------------------------------
// sparse_tree_layer_grouper: one layer pass of a bottom-up 64-way tree build
// Writes each sorted child to the node pool and closes runs of children that
// share a parent prefix into parent records for the next layer.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : child words in ascending Z-order key order; last_child marks the
//            final child of the layer.
//   rsp_*  : result words. Per child, in order: the parent of the previous
//            run when the prefix changes, the child pool write, and the
//            closing parent when last_child is set.
//   csr_*  : register writes (index 0 layer_scale, index 1 pool_base; a
//            pool_base write also restarts the pool index count). Write only
//            while idle. csr_ready is always high.
// Result path: the result words of a child are registered in the result queue
//   and leave it on rsp_* in order, after any earlier words still waiting.
// Throughput: one child per cycle while each child causes one result word and
//   rsp_ready stays high; every parent word is an extra result word. The limit
//   is the result queue (four words), draining one word per cycle of rsp_ready.
// req_ready is high while the queue holds at most one word, so a child is
//   taken while an earlier result still waits to be taken.
// Receiver stall: results hold in the queue; req_ready drops at two words.
// Reset: queue empty, no open run, pool index count zero, layer_scale 8,
//   pool_base 0.
// ---------------------------------------------------------------------------
module sparse_tree_layer_grouper (
   input  logic                              clock,
   input  logic                              reset,
   // child channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [stlg_pkg::KeyWidth-1:0]     req_child_key,
   input  logic                              req_child_is_leaf,
   input  logic                              req_child_is_absolute,
   input  logic [stlg_pkg::IndexWidth-1:0]   req_child_pointer,
   input  logic [stlg_pkg::MaskWidth-1:0]    req_child_mask,
   input  logic                              req_last_child,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_item_kind,
   output logic [stlg_pkg::IndexWidth-1:0]   rsp_pool_index,
   output logic [stlg_pkg::KeyWidth-1:0]     rsp_node_key,
   output logic                              rsp_node_is_leaf,
   output logic                              rsp_node_is_absolute,
   output logic [stlg_pkg::IndexWidth-1:0]   rsp_node_pointer,
   output logic [stlg_pkg::MaskWidth-1:0]    rsp_node_mask,
   output logic                              rsp_end_of_run,
   output logic                              rsp_end_of_layer,
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [stlg_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [stlg_pkg::IndexWidth-1:0]   csr_data
);
   import stlg_pkg::*;

   // registers
   logic [ScaleWidth-1:0]    layer_scale_ff;
   logic [IndexWidth-1:0]    pool_base_ff;
   logic                     group_open_ff, group_open_in;
   logic [KeyWidth-1:0]      open_key_ff, open_key_in;
   logic [MaskWidth-1:0]     open_mask_ff, open_mask_in;
   logic [IndexWidth-1:0]    open_first_ff, open_first_in;
   logic [IndexWidth-1:0]    written_count_ff, written_count_in;

   rsp_word_type             queue_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0] count_ff, count_in;

   // per-child logic
   logic                     req_fire, rsp_fire, csr_fire;
   logic [6:0]               prefix_shift;
   logic [6:0]               bit_shift;
   logic [KeyWidth-1:0]      prefix_mask;
   logic [KeyWidth-1:0]      shifted_key;
   logic [5:0]               bit_index;
   logic [MaskWidth-1:0]     child_bit;
   logic [IndexWidth-1:0]    child_index;
   logic                     close_prev;
   logic                     start_run;
   logic [KeyWidth-1:0]      run_key;
   logic [MaskWidth-1:0]     run_mask;
   logic [IndexWidth-1:0]    run_first;
   rsp_word_type             prev_parent_word, child_word, last_parent_word;
   rsp_word_type             slot0_word, slot1_word;
   logic [1:0]               push_count;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign csr_ready = 1'b1;

   // take a child while the queue has room for three words
   assign req_ready = (count_ff <= QueueCntWidth'(1));

   // prefix and child-bit positions from the layer scale
   always_comb begin
      prefix_shift = 7'(layer_scale_ff) * 7'd3;
      if (layer_scale_ff < ScaleWidth'(2)) begin
         bit_shift = 7'd0;
      end else begin
         bit_shift = (7'(layer_scale_ff) - 7'd2) * 7'd3;
      end
      // a shift of 64 or more empties the prefix and pins the bit index to 0
      if (prefix_shift >= 7'd64) begin
         prefix_mask = '0;
      end else begin
         prefix_mask = ~64'd0 << prefix_shift[5:0];
      end
      shifted_key = req_child_key >> bit_shift[5:0];
      if (bit_shift >= 7'd64) begin
         bit_index = 6'd0;
      end else begin
         bit_index = shifted_key[5:0];
      end
      child_bit = 64'd1 << bit_index;
   end

   assign child_index = pool_base_ff + written_count_ff;

   // run tracking: a prefix change closes the open run
   always_comb begin
      close_prev = group_open_ff &&
                   (((req_child_key ^ open_key_ff) & prefix_mask) != '0);
      start_run  = !group_open_ff || close_prev;
      run_key    = start_run ? (req_child_key & prefix_mask) : open_key_ff;
      run_mask   = (start_run ? '0 : open_mask_ff) | child_bit;
      run_first  = start_run ? child_index : open_first_ff;
   end

   // result words of this child
   always_comb begin
      prev_parent_word.item_kind        = KIND_PARENT;
      prev_parent_word.pool_index       = '0;
      prev_parent_word.node_key         = open_key_ff;
      prev_parent_word.node_is_leaf     = 1'b0;
      prev_parent_word.node_is_absolute = 1'b0;
      prev_parent_word.node_pointer     = open_first_ff;
      prev_parent_word.node_mask        = open_mask_ff;
      prev_parent_word.end_of_run       = 1'b0;
      prev_parent_word.end_of_layer     = 1'b0;

      child_word.item_kind        = KIND_CHILD;
      child_word.pool_index       = child_index;
      child_word.node_key         = req_child_key;
      child_word.node_is_leaf     = req_child_is_leaf;
      child_word.node_is_absolute = req_child_is_absolute;
      child_word.node_pointer     = req_child_pointer;
      child_word.node_mask        = req_child_mask;
      child_word.end_of_run       = !req_last_child;
      child_word.end_of_layer     = 1'b0;

      last_parent_word.item_kind        = KIND_PARENT;
      last_parent_word.pool_index       = '0;
      last_parent_word.node_key         = run_key;
      last_parent_word.node_is_leaf     = 1'b0;
      last_parent_word.node_is_absolute = 1'b0;
      last_parent_word.node_pointer     = run_first;
      last_parent_word.node_mask        = run_mask;
      last_parent_word.end_of_run       = 1'b1;
      last_parent_word.end_of_layer     = 1'b1;

      // pack the words into consecutive queue slots
      slot0_word = close_prev ? prev_parent_word : child_word;
      slot1_word = close_prev ? child_word : last_parent_word;
      push_count = 2'd1 + 2'(close_prev) + 2'(req_last_child);
   end

   // next state of the run and the pool index count
   always_comb begin
      group_open_in    = group_open_ff;
      open_key_in      = open_key_ff;
      open_mask_in     = open_mask_ff;
      open_first_in    = open_first_ff;
      written_count_in = written_count_ff;
      if (req_fire) begin
         written_count_in = written_count_ff + IndexWidth'(1);
         if (req_last_child) begin
            // the layer is done: drop the run
            group_open_in = 1'b0;
            open_key_in   = '0;
            open_mask_in  = '0;
            open_first_in = '0;
         end else begin
            group_open_in = 1'b1;
            open_key_in   = run_key;
            open_mask_in  = run_mask;
            open_first_in = run_first;
         end
      end
      if (csr_fire && (csr_index == CSR_POOL_BASE)) begin
         written_count_in = '0;
      end
   end

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_fire) begin
         wr_ptr_in = wr_ptr_ff + QueuePtrWidth'(push_count);
         count_in  = count_in + QueueCntWidth'(push_count);
      end
      if (rsp_fire) begin
         rd_ptr_in = rd_ptr_ff + QueuePtrWidth'(1);
         count_in  = count_in - QueueCntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_scale_ff   <= LAYER_SCALE_RESET;
         pool_base_ff     <= '0;
         group_open_ff    <= 1'b0;
         open_key_ff      <= '0;
         open_mask_ff     <= '0;
         open_first_ff    <= '0;
         written_count_ff <= '0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         count_ff         <= '0;
      end else begin
         if (csr_fire) begin
            case (csr_index)
               CSR_LAYER_SCALE: begin
                  layer_scale_ff <= csr_data[ScaleWidth-1:0];
               end
               CSR_POOL_BASE: begin
                  pool_base_ff <= csr_data;
               end
               default: begin
                  // no register at this index
               end
            endcase
         end
         group_open_ff    <= group_open_in;
         open_key_ff      <= open_key_in;
         open_mask_ff     <= open_mask_in;
         open_first_ff    <= open_first_in;
         written_count_ff <= written_count_in;
         wr_ptr_ff        <= wr_ptr_in;
         rd_ptr_ff        <= rd_ptr_in;
         count_ff         <= count_in;
      end
   end

   // result queue storage: hold words until the receiver takes them
   always_ff @(posedge clock) begin
      if (req_fire) begin
         queue_ff[wr_ptr_ff] <= slot0_word;
         if (push_count >= 2'd2) begin
            queue_ff[wr_ptr_ff + QueuePtrWidth'(1)] <= slot1_word;
         end
         if (push_count == 2'd3) begin
            queue_ff[wr_ptr_ff + QueuePtrWidth'(2)] <= last_parent_word;
         end
      end
   end

   assign rsp_valid            = (count_ff != '0);
   assign rsp_item_kind        = queue_ff[rd_ptr_ff].item_kind;
   assign rsp_pool_index       = queue_ff[rd_ptr_ff].pool_index;
   assign rsp_node_key         = queue_ff[rd_ptr_ff].node_key;
   assign rsp_node_is_leaf     = queue_ff[rd_ptr_ff].node_is_leaf;
   assign rsp_node_is_absolute = queue_ff[rd_ptr_ff].node_is_absolute;
   assign rsp_node_pointer     = queue_ff[rd_ptr_ff].node_pointer;
   assign rsp_node_mask        = queue_ff[rd_ptr_ff].node_mask;
   assign rsp_end_of_run       = queue_ff[rd_ptr_ff].end_of_run;
   assign rsp_end_of_layer     = queue_ff[rd_ptr_ff].end_of_layer;

   // assertions
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCntWidth'(QueueDepth))
      else $error("result queue over its depth");

   a_last_closes_run: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_last_child |=> !group_open_ff && (count_ff >= QueueCntWidth'(2)))
      else $error("last child did not close the run and queue its parent");

   a_pool_index_step: assert property (@(posedge clock) disable iff (reset)
      req_fire && !(csr_fire && (csr_index == CSR_POOL_BASE)) |=>
      written_count_ff == IndexWidth'($past(written_count_ff) + IndexWidth'(1)))
      else $error("pool index count did not advance by one");

   a_pointer_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff != QueueCntWidth'(QueueDepth)) && (count_ff != '0) |->
      (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with fill count");

endmodule
